>>> rtl/admittance_filter_1d_unit_macros.svh
// Assertion macros used by the admittance filter RTL.
`ifndef ADMITTANCE_FILTER_1D_UNIT_MACROS_SVH
`define ADMITTANCE_FILTER_1D_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define AFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define AFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/afd_pkg.sv
// Types and constants of the admittance filter.
package afd_pkg;

  localparam int unsigned AccW  = 128;  // exact accumulator, units of 2^-64
  localparam int unsigned MplW  = 34;   // widest serial multiplier operand
  localparam int unsigned CntW  = 6;    // serial step counter
  localparam int unsigned QuoW  = 41;   // quotient bits below overflow limit
  localparam int unsigned DivSteps = QuoW + 1;

  // Register indexes
  localparam logic [1:0] CFG_MASS      = 2'd0;
  localparam logic [1:0] CFG_DAMPING   = 2'd1;
  localparam logic [1:0] CFG_STIFFNESS = 2'd2;
  localparam logic [1:0] CFG_PERIOD    = 2'd3;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_SAT   = 2'd1,
    FAULT_CZERO = 2'd2
  } fault_e;

  typedef struct packed {
    logic signed [31:0] desired_position;
    logic signed [31:0] desired_force;
    logic signed [31:0] measured_force;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] command_position;
    logic [1:0]         fault;
  } out_word_t;

  // Command to the serial multiply-accumulate unit
  typedef struct packed {
    logic            start;
    logic            clear;
    logic            sgn;
    logic [CntW-1:0] len;
    logic [AccW-1:0] mcand;
    logic [MplW-1:0] mplier;
  } mac_cmd_t;

  // Command to the serial divider
  typedef struct packed {
    logic            start;
    logic [AccW-1:0] mag;
    logic [AccW-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic            busy;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

endpackage

>>> rtl/afd_mac.sv
// Bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle.
module afd_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  afd_pkg::mac_cmd_t     cmd_i,
  output logic                  busy_o,
  output logic [afd_pkg::AccW-1:0] acc_o
);
  import afd_pkg::*;

  logic [CntW-1:0] cnt_q;
  logic [AccW-1:0] mcand_q, acc_q;
  logic [MplW-1:0] mpl_q;
  logic            sgn_q;
  logic            sub;

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;
  // sign bit of a two's complement multiplier carries negative weight
  assign sub    = sgn_q && (cnt_q == CntW'(1));

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= cmd_i.len;
    end else if (busy_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q <= cmd_i.mcand;
      mpl_q   <= cmd_i.mplier;
      sgn_q   <= cmd_i.sgn;
      if (cmd_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_o) begin
      if (mpl_q[0]) begin
        acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
      end
      mcand_q <= {mcand_q[AccW-2:0], 1'b0};
      mpl_q   <= {1'b0, mpl_q[MplW-1:1]};
    end
  end

endmodule

>>> rtl/afd_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detection.
module afd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  afd_pkg::div_cmd_t cmd_i,
  output afd_pkg::div_res_t res_o
);
  import afd_pkg::*;

  logic [CntW-1:0] cnt_q;
  logic [AccW-1:0] rem_q, den_q;
  logic [QuoW-1:0] quo_q;
  logic            ovf_q;
  logic            ge;

  assign ge = (rem_q >= den_q);

  assign res_o.busy = (cnt_q != '0);
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= CntW'(DivSteps);
    end else if (res_o.busy) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // first step tests the overflow limit, the rest build the quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= cmd_i.mag;
      den_q <= {cmd_i.den[AccW-QuoW-1:0], {QuoW{1'b0}}};
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (res_o.busy) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      if (cnt_q == CntW'(DivSteps)) begin
        ovf_q <= ge;
      end else begin
        quo_q <= {quo_q[QuoW-2:0], ge};
      end
      den_q <= {1'b0, den_q[AccW-1:1]};
    end
  end

endmodule

>>> rtl/admittance_filter_1d_unit.sv
// One-axis admittance filter: bilinear mass-spring-damper, one command word per input word.
// Per input word (no numerator terms and no quotient when the C coefficient is zero), the
// coefficients T^2, T*D, T^2*K and the numerator terms are formed on one bit-serial
// shift-add unit, one multiplier bit per cycle (24+24+32+32+32+34 steps), and the quotient
// comes from a restoring divider at one bit per cycle (42 steps). One word is in work at a
// time; the next is taken while the previous result still waits in the output register.
`include "admittance_filter_1d_unit_macros.svh"

module admittance_filter_1d_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afd_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afd_pkg::out_word_t out_data_o
);
  import afd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TT_GO, S_TT_W, S_TD_GO, S_TD_W, S_TTK_GO, S_TTK_W, S_COEF, S_CHK,
    S_N1_GO, S_N1_W, S_N2_GO, S_N2_W, S_N3_GO, S_N3_W, S_DIV_GO, S_DIV_W, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0] mass_q, damping_q, stiffness_q;
  logic [23:0] period_q;

  // word in work
  logic signed [31:0] xd_q, f0_q;
  logic signed [33:0] fsum_q;
  logic signed [31:0] e1_q, e2_q, f1_q, f2_q;
  logic [47:0]        tt_q;
  logic [55:0]        td_q;
  logic [79:0]        ttk_q;
  logic [AccW-1:0]    ca_q, cb_q, cc_q;
  logic               neg_q, czero_q;

  mac_cmd_t        mac_cmd;
  logic            mac_busy;
  logic [AccW-1:0] acc;
  div_cmd_t        div_cmd;
  div_res_t        div_res;

  afd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  afd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // input force error, saturated
  logic signed [32:0] fdiff;
  logic signed [31:0] f0_in;
  logic signed [33:0] fsum_in;
  assign fdiff = 33'(in_data_i.desired_force) - 33'(in_data_i.measured_force);
  always_comb begin
    if (fdiff[32] != fdiff[31]) begin
      f0_in = fdiff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      f0_in = fdiff[31:0];
    end
  end
  assign fsum_in = 34'(f0_in) + (34'(f1_q) <<< 1) + 34'(f2_q);

  // coefficients in units of 2^-64
  logic [AccW-1:0] m4, td2, ttk, tsq;
  assign m4  = {46'b0, mass_q, 50'b0};
  assign td2 = {47'b0, td_q, 25'b0};
  assign ttk = {48'b0, ttk_q};
  assign tsq = {64'b0, tt_q, 16'b0};

  // commands to the serial units
  always_comb begin
    mac_cmd = '0;
    unique case (state_q)
      S_TT_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b1, sgn: 1'b0, len: CntW'(24),
                    mcand: AccW'(period_q), mplier: MplW'(period_q)};
      end
      S_TD_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b1, sgn: 1'b0, len: CntW'(24),
                    mcand: AccW'(damping_q), mplier: MplW'(period_q)};
      end
      S_TTK_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b1, sgn: 1'b0, len: CntW'(32),
                    mcand: AccW'(tt_q), mplier: MplW'(stiffness_q)};
      end
      S_N1_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b1, sgn: 1'b1, len: CntW'(32),
                    mcand: cb_q, mplier: MplW'($unsigned(e1_q))};
      end
      S_N2_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b0, sgn: 1'b1, len: CntW'(32),
                    mcand: ca_q, mplier: MplW'($unsigned(e2_q))};
      end
      S_N3_GO: begin
        mac_cmd = '{start: 1'b1, clear: 1'b0, sgn: 1'b1, len: CntW'(34),
                    mcand: AccW'(0) - tsq, mplier: $unsigned(fsum_q)};
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  assign div_cmd.start = (state_q == S_DIV_GO);
  assign div_cmd.mag   = acc[AccW-1] ? AccW'(0) - acc : acc;
  assign div_cmd.den   = cc_q;

  // final result
  logic signed [42:0] qs, xsum;
  logic signed [31:0] xc;
  logic               sat;
  logic signed [32:0] ediff;
  logic signed [31:0] e_new;
  always_comb begin
    qs = neg_q ? 43'sd0 - $signed({2'b0, div_res.quo}) : $signed({2'b0, div_res.quo});
    xsum = 43'(xd_q) + qs;
    if (div_res.ovf) begin
      xc  = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else if (xsum[42:31] != {12{xsum[42]}}) begin
      xc  = xsum[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      sat = 1'b1;
    end else begin
      xc  = xsum[31:0];
      sat = 1'b0;
    end
    ediff = 33'(xd_q) - 33'(xc);
    if (ediff[32] != ediff[31]) begin
      e_new = ediff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      e_new = ediff[31:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= 32'd65536;
      damping_q   <= '0;
      stiffness_q <= '0;
      period_q    <= 24'd33554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASS:      mass_q      <= cfg_data_i;
        CFG_DAMPING:   damping_q   <= cfg_data_i;
        CFG_STIFFNESS: stiffness_q <= cfg_data_i;
        CFG_PERIOD:    period_q    <= cfg_data_i[23:0];
        default:       mass_q      <= mass_q;
      endcase
    end
  end

  // sequencer, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      f1_q        <= '0;
      f2_q        <= '0;
      xd_q        <= '0;
      f0_q        <= '0;
      fsum_q      <= '0;
      tt_q        <= '0;
      td_q        <= '0;
      ttk_q       <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      cc_q        <= '0;
      neg_q       <= 1'b0;
      czero_q     <= 1'b0;
    end else begin
      // the final step reloads the register itself
      if (out_valid_o && out_ready_i && (state_q != S_FIN)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            xd_q    <= in_data_i.desired_position;
            f0_q    <= f0_in;
            fsum_q  <= fsum_in;
            state_q <= S_TT_GO;
          end
        end
        S_TT_GO:  state_q <= S_TT_W;
        S_TT_W: begin
          if (!mac_busy) begin
            tt_q    <= acc[47:0];
            state_q <= S_TD_GO;
          end
        end
        S_TD_GO:  state_q <= S_TD_W;
        S_TD_W: begin
          if (!mac_busy) begin
            td_q    <= acc[55:0];
            state_q <= S_TTK_GO;
          end
        end
        S_TTK_GO: state_q <= S_TTK_W;
        S_TTK_W: begin
          if (!mac_busy) begin
            ttk_q   <= acc[79:0];
            state_q <= S_COEF;
          end
        end
        S_COEF: begin
          ca_q    <= m4 - td2 + ttk;
          cb_q    <= {ttk[AccW-2:0], 1'b0} - {m4[AccW-2:0], 1'b0};
          cc_q    <= m4 + td2 + ttk;
          state_q <= S_CHK;
        end
        S_CHK: begin
          czero_q <= (cc_q == '0);
          state_q <= (cc_q == '0) ? S_FIN : S_N1_GO;
        end
        S_N1_GO:  state_q <= S_N1_W;
        S_N1_W:   if (!mac_busy) state_q <= S_N2_GO;
        S_N2_GO:  state_q <= S_N2_W;
        S_N2_W:   if (!mac_busy) state_q <= S_N3_GO;
        S_N3_GO:  state_q <= S_N3_W;
        S_N3_W:   if (!mac_busy) state_q <= S_DIV_GO;
        S_DIV_GO: begin
          neg_q   <= acc[AccW-1];
          state_q <= S_DIV_W;
        end
        S_DIV_W:  if (!div_res.busy) state_q <= S_FIN;
        S_FIN: begin
          // wait for a free output register
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            if (czero_q) begin
              out_data_o <= '{command_position: xd_q, fault: FAULT_CZERO};
            end else begin
              out_data_o <= '{command_position: xc,
                              fault: sat ? FAULT_SAT : FAULT_OK};
              e1_q <= e_new;
              e2_q <= e1_q;
              f1_q <= f0_q;
              f2_q <= f1_q;
            end
            czero_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  `AFD_ASSERT_NEVER(a_units_exclusive, clk_i, rst_ni, mac_busy && div_res.busy, "both busy")
  `AFD_ASSERT(a_one_in_work, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "2nd")
  `AFD_ASSERT(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_FIN), "fin")

endmodule
